/* hw/rtl/hsr_pkg.sv */
// Shared types, constants and spelling tables of the Hangul syllable romanizer.
package hsr_pkg;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned LetterW = 8;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned OffW    = 14;
  localparam int unsigned QuotW   = 9;
  localparam int unsigned ProdW   = 2 * OffW;

  localparam logic [CodeW-1:0] SylBase = 16'hAC00;
  localparam logic [CodeW-1:0] SylLast = 16'hD7A3;

  // floor(off / 588) == (off * 14267) >> 23 and floor(off / 28) == (off * 9363) >> 18
  // for every offset in the syllable block.
  localparam logic [OffW-1:0] IniRecip  = 14'd14267;
  localparam int unsigned     IniShift  = 23;
  localparam logic [OffW-1:0] QuotRecip = 14'd9363;
  localparam int unsigned     QuotShift = 18;

  localparam logic [OffW-1:0]  PerVowel    = 14'd28;
  localparam logic [QuotW-1:0] VowPerIni   = 9'd21;
  localparam logic [IdxW-1:0]  NumInitials = 5'd19;
  localparam logic [IdxW-1:0]  NumVowels   = 5'd21;
  localparam logic [IdxW-1:0]  RieulIni    = 5'd5;
  localparam logic [IdxW-1:0]  RieulFin    = 5'd8;

  localparam logic [LetterW-1:0] Nul = 8'h00;

  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [LetterW-1:0] letter_t;

  // One decomposed item on its way from the front end to the emitter.
  typedef struct packed {
    logic             is_syl;
    logic [CodeW-1:0] unit;
    idx_t             ini;
    idx_t             vow;
    idx_t             fin;
    logic             use_l;
  } hsr_entry_t;

  // Spellings are left aligned: the first letter sits in the top byte.
  typedef struct packed {
    logic [1:0]             len;
    logic [2*LetterW-1:0]   ch;
  } spell2_t;

  typedef struct packed {
    logic [1:0]             len;
    logic [3*LetterW-1:0]   ch;
  } spell3_t;

  function automatic spell2_t ini_spell(input idx_t ini, input logic use_l);
    spell2_t s;
    s = '{len: 2'd0, ch: '0};
    if (use_l) begin
      s = '{len: 2'd1, ch: {"l", Nul}};
    end else begin
      unique case (ini)
        5'd0:    s = '{len: 2'd1, ch: {"g", Nul}};
        5'd1:    s = '{len: 2'd2, ch: "kk"};
        5'd2:    s = '{len: 2'd1, ch: {"n", Nul}};
        5'd3:    s = '{len: 2'd1, ch: {"d", Nul}};
        5'd4:    s = '{len: 2'd2, ch: "tt"};
        5'd5:    s = '{len: 2'd1, ch: {"r", Nul}};
        5'd6:    s = '{len: 2'd1, ch: {"m", Nul}};
        5'd7:    s = '{len: 2'd1, ch: {"b", Nul}};
        5'd8:    s = '{len: 2'd2, ch: "pp"};
        5'd9:    s = '{len: 2'd1, ch: {"s", Nul}};
        5'd10:   s = '{len: 2'd2, ch: "ss"};
        5'd11:   s = '{len: 2'd0, ch: '0};
        5'd12:   s = '{len: 2'd1, ch: {"j", Nul}};
        5'd13:   s = '{len: 2'd2, ch: "jj"};
        5'd14:   s = '{len: 2'd2, ch: "ch"};
        5'd15:   s = '{len: 2'd1, ch: {"k", Nul}};
        5'd16:   s = '{len: 2'd1, ch: {"t", Nul}};
        5'd17:   s = '{len: 2'd1, ch: {"p", Nul}};
        5'd18:   s = '{len: 2'd1, ch: {"h", Nul}};
        default: s = '{len: 2'd0, ch: '0};
      endcase
    end
    return s;
  endfunction

  function automatic spell3_t vow_spell(input idx_t vow);
    spell3_t s;
    unique case (vow)
      5'd0:    s = '{len: 2'd1, ch: {"a", Nul, Nul}};
      5'd1:    s = '{len: 2'd2, ch: {"ae", Nul}};
      5'd2:    s = '{len: 2'd2, ch: {"ya", Nul}};
      5'd3:    s = '{len: 2'd3, ch: "yae"};
      5'd4:    s = '{len: 2'd2, ch: {"eo", Nul}};
      5'd5:    s = '{len: 2'd1, ch: {"e", Nul, Nul}};
      5'd6:    s = '{len: 2'd3, ch: "yeo"};
      5'd7:    s = '{len: 2'd2, ch: {"ye", Nul}};
      5'd8:    s = '{len: 2'd1, ch: {"o", Nul, Nul}};
      5'd9:    s = '{len: 2'd2, ch: {"wa", Nul}};
      5'd10:   s = '{len: 2'd3, ch: "wae"};
      5'd11:   s = '{len: 2'd2, ch: {"oe", Nul}};
      5'd12:   s = '{len: 2'd2, ch: {"yo", Nul}};
      5'd13:   s = '{len: 2'd1, ch: {"u", Nul, Nul}};
      5'd14:   s = '{len: 2'd2, ch: {"wo", Nul}};
      5'd15:   s = '{len: 2'd2, ch: {"we", Nul}};
      5'd16:   s = '{len: 2'd2, ch: {"wi", Nul}};
      5'd17:   s = '{len: 2'd2, ch: {"yu", Nul}};
      5'd18:   s = '{len: 2'd2, ch: {"eu", Nul}};
      5'd19:   s = '{len: 2'd2, ch: {"ui", Nul}};
      5'd20:   s = '{len: 2'd1, ch: {"i", Nul, Nul}};
      default: s = '{len: 2'd1, ch: {"i", Nul, Nul}};
    endcase
    return s;
  endfunction

  function automatic spell2_t fin_spell(input idx_t fin);
    spell2_t s;
    unique case (fin)
      5'd0:    s = '{len: 2'd0, ch: '0};
      5'd1:    s = '{len: 2'd1, ch: {"k", Nul}};
      5'd2:    s = '{len: 2'd1, ch: {"k", Nul}};
      5'd3:    s = '{len: 2'd2, ch: "ks"};
      5'd4:    s = '{len: 2'd1, ch: {"n", Nul}};
      5'd5:    s = '{len: 2'd2, ch: "nj"};
      5'd6:    s = '{len: 2'd2, ch: "nh"};
      5'd7:    s = '{len: 2'd1, ch: {"t", Nul}};
      5'd8:    s = '{len: 2'd1, ch: {"l", Nul}};
      5'd9:    s = '{len: 2'd2, ch: "lg"};
      5'd10:   s = '{len: 2'd2, ch: "lm"};
      5'd11:   s = '{len: 2'd2, ch: "lb"};
      5'd12:   s = '{len: 2'd2, ch: "ls"};
      5'd13:   s = '{len: 2'd2, ch: "lt"};
      5'd14:   s = '{len: 2'd2, ch: "lp"};
      5'd15:   s = '{len: 2'd2, ch: "lh"};
      5'd16:   s = '{len: 2'd1, ch: {"m", Nul}};
      5'd17:   s = '{len: 2'd1, ch: {"p", Nul}};
      5'd18:   s = '{len: 2'd2, ch: "ps"};
      5'd19:   s = '{len: 2'd1, ch: {"t", Nul}};
      5'd20:   s = '{len: 2'd2, ch: "ss"};
      5'd21:   s = '{len: 2'd2, ch: "ng"};
      5'd22:   s = '{len: 2'd1, ch: {"t", Nul}};
      5'd23:   s = '{len: 2'd1, ch: {"t", Nul}};
      5'd24:   s = '{len: 2'd1, ch: {"k", Nul}};
      5'd25:   s = '{len: 2'd1, ch: {"t", Nul}};
      5'd26:   s = '{len: 2'd1, ch: {"p", Nul}};
      5'd27:   s = '{len: 2'd1, ch: {"h", Nul}};
      default: s = '{len: 2'd0, ch: '0};
    endcase
    return s;
  endfunction

  function automatic letter_t pick2(input logic [2*LetterW-1:0] ch, input logic idx);
    return idx ? ch[LetterW-1:0] : ch[2*LetterW-1:LetterW];
  endfunction

  function automatic letter_t pick3(input logic [3*LetterW-1:0] ch, input logic [1:0] idx);
    letter_t l;
    unique case (idx)
      2'd0:    l = ch[3*LetterW-1:2*LetterW];
      2'd1:    l = ch[2*LetterW-1:LetterW];
      default: l = ch[LetterW-1:0];
    endcase
    return l;
  endfunction

endpackage

/* hw/rtl/hsr_if.sv */
// Valid/ready stream interfaces for the romanizer's input and output channels.
interface hsr_in_if;
  import hsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_unit;
  logic             first_of_line;

  modport source (output valid, output code_unit, output first_of_line, input ready);
  modport sink   (input valid, input code_unit, input first_of_line, output ready);
endinterface

interface hsr_out_if;
  import hsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] char_code;
  logic             last_of_run;

  modport source (output valid, output char_code, output last_of_run, input ready);
  modport sink   (input valid, input char_code, input last_of_run, output ready);
endinterface

/* hw/rtl/hsr_front.sv */
// Front end: accepts code units, splits syllables into parts and tracks line context.
module hsr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  hsr_in_if.sink             in_i,
  output logic               entry_valid_o,
  input  logic               entry_ready_i,
  output hsr_pkg::hsr_entry_t entry_o
);
  import hsr_pkg::*;

  logic [CodeW-1:0] off_full;
  logic [OffW-1:0]  off;
  logic [ProdW-1:0] ini_prod;
  logic [ProdW-1:0] quot_prod;
  logic             in_syl;

  logic             s1_valid_q, s1_valid_d;
  logic [CodeW-1:0] s1_unit_q;
  logic             s1_first_q;
  logic             s1_syl_q;
  logic [OffW-1:0]  s1_off_q;
  idx_t             s1_ini_q;
  logic [QuotW-1:0] s1_quot_q;

  logic             prev_syl_q, prev_syl_d;
  idx_t             prev_fin_q, prev_fin_d;

  logic             push;
  logic [OffW-1:0]  quot28;
  logic [QuotW-1:0] ini21;
  idx_t             fin;
  idx_t             vow;
  logic             eff_syl;
  idx_t             eff_fin;

  // Stage 1: range check and the two reciprocal multiplications.
  assign off_full  = in_i.code_unit - SylBase;
  assign off       = off_full[OffW-1:0];
  assign in_syl    = (in_i.code_unit >= SylBase) && (in_i.code_unit <= SylLast);
  assign ini_prod  = ProdW'(off) * ProdW'(IniRecip);
  assign quot_prod = ProdW'(off) * ProdW'(QuotRecip);

  assign in_i.ready = !s1_valid_q || entry_ready_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_unit_q  <= in_i.code_unit;
      s1_first_q <= in_i.first_of_line;
      s1_syl_q   <= in_syl;
      s1_off_q   <= off;
      s1_ini_q   <= ini_prod[IniShift +: IdxW];
      s1_quot_q  <= quot_prod[QuotShift +: QuotW];
    end
  end

  // Stage 2: remainders, rieul context and transfer into the queue.
  assign quot28 = OffW'(s1_quot_q) * PerVowel;
  assign ini21  = QuotW'(s1_ini_q) * VowPerIni;
  assign fin    = IdxW'(s1_off_q - quot28);
  assign vow    = IdxW'(s1_quot_q - ini21);

  assign eff_syl = !s1_first_q && prev_syl_q;
  assign eff_fin = s1_first_q ? '0 : prev_fin_q;

  assign push          = s1_valid_q && entry_ready_i;
  assign entry_valid_o = s1_valid_q;

  always_comb begin
    entry_o.is_syl = s1_syl_q;
    entry_o.unit   = s1_unit_q;
    entry_o.ini    = s1_ini_q;
    entry_o.vow    = vow;
    entry_o.fin    = fin;
    entry_o.use_l  = s1_syl_q && (s1_ini_q == RieulIni) && eff_syl && (eff_fin == RieulFin);
  end

  always_comb begin
    prev_syl_d = prev_syl_q;
    prev_fin_d = prev_fin_q;
    if (push) begin
      prev_syl_d = s1_syl_q;
      prev_fin_d = s1_syl_q ? fin : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_syl_q <= 1'b0;
      prev_fin_q <= '0;
    end else begin
      prev_syl_q <= prev_syl_d;
      prev_fin_q <= prev_fin_d;
    end
  end

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !entry_ready_i |=> s1_valid_q && $stable(s1_unit_q))
    else $error("front stage lost or changed an item while stalled");

  a_parts_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o && entry_o.is_syl |-> (entry_o.ini < NumInitials) && (entry_o.vow < NumVowels))
    else $error("syllable split gave an out-of-range part");

endmodule

/* hw/rtl/hsr_queue.sv */
// Short first-in first-out queue of decomposed items between front end and emitter.
module hsr_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  hsr_pkg::hsr_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output hsr_pkg::hsr_entry_t pop_entry_o
);
  import hsr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsr_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count overran its depth");

endmodule

/* hw/rtl/hsr_back.sv */
// Back end: walks the letters of each queued item and drives the output register.
module hsr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                entry_valid_i,
  output logic                entry_ready_o,
  input  hsr_pkg::hsr_entry_t entry_i,
  hsr_out_if.source           out_o
);
  import hsr_pkg::*;

  typedef enum logic [2:0] {
    PhIni = 3'b001,
    PhVow = 3'b010,
    PhFin = 3'b100
  } phase_e;

  phase_e           phase_q, phase_d, cur_phase;
  logic [1:0]       idx_q, idx_d;
  spell2_t          ini_s;
  spell3_t          vow_s;
  spell2_t          fin_s;
  letter_t          letter;
  logic [1:0]       cur_len;
  logic             part_end;
  logic             last;
  logic             out_free;
  logic             emit;

  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] out_char_q;
  logic             out_last_q;

  assign ini_s = ini_spell(entry_i.ini, entry_i.use_l);
  assign vow_s = vow_spell(entry_i.vow);
  assign fin_s = fin_spell(entry_i.fin);

  // A silent initial is skipped straight into the vowel.
  assign cur_phase = ((phase_q == PhIni) && (ini_s.len == 2'd0)) ? PhVow : phase_q;

  always_comb begin
    unique case (cur_phase)
      PhIni: begin
        letter  = pick2(ini_s.ch, idx_q[0]);
        cur_len = ini_s.len;
      end
      PhVow: begin
        letter  = pick3(vow_s.ch, idx_q);
        cur_len = vow_s.len;
      end
      PhFin: begin
        letter  = pick2(fin_s.ch, idx_q[0]);
        cur_len = fin_s.len;
      end
      default: begin
        letter  = '0;
        cur_len = 2'd1;
      end
    endcase
  end

  assign part_end = (idx_q == cur_len - 2'd1);
  assign last     = !entry_i.is_syl ||
                    (part_end && ((cur_phase == PhFin) ||
                                  ((cur_phase == PhVow) && (fin_s.len == 2'd0))));

  assign out_free      = !out_valid_q || out_o.ready;
  assign emit          = entry_valid_i && out_free;
  assign entry_ready_o = emit && last;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (emit) begin
      if (last) begin
        phase_d = PhIni;
        idx_d   = '0;
      end else if (part_end) begin
        phase_d = (cur_phase == PhIni) ? PhVow : PhFin;
        idx_d   = '0;
      end else begin
        phase_d = cur_phase;
        idx_d   = idx_q + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIni;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= entry_i.is_syl ? {{(CodeW - LetterW){1'b0}}, letter} : entry_i.unit;
      out_last_q <= last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.char_code   = out_char_q;
  assign out_o.last_of_run = out_last_q;

  a_mid_run_is_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_char_q[CodeW-1:LetterW] == '0)
    else $error("non-final character of a run is not a romanized letter");

  a_head_held_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIni) || (idx_q != 2'd0) |-> entry_valid_i)
    else $error("queue head vanished while its letters were being emitted");

endmodule

/* hw/rtl/hangul_syllable_romanizer_core.sv */
// Top level of the Hangul syllable romanizer: front end, item queue and letter emitter.
//
//   channel  modport  direction  payload                      moves on
//   in_i     sink     into core  code_unit, first_of_line      valid & ready
//   out_o    source   out of it  char_code, last_of_run        valid & ready
//
// An input transfer is split in the front end (reciprocal multiply, then remainders and
// rieul context) and lands in a QueueDepth-entry queue. The emitter sends one character
// per cycle while the output is ready: one for a passed-through unit, one to seven for
// a syllable, so the output register sets the sustained rate. On an idle core an input
// passes stage 1, the queue and the output register before its first character is valid.
// Reset clears the line context, the queue and the output register; payload holds.
// Either side may stall freely: the queue and the output register absorb it.
module hangul_syllable_romanizer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsr_in_if.sink     in_i,
  hsr_out_if.source  out_o
);
  import hsr_pkg::*;

  // Front end to queue.
  logic       fq_valid;
  logic       fq_ready;
  hsr_entry_t fq_entry;

  // Queue to emitter.
  logic       qb_valid;
  logic       qb_ready;
  hsr_entry_t qb_entry;

  // Classify, split and resolve the rieul spelling; advance only when the queue has room.
  hsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .entry_valid_o (fq_valid),
    .entry_ready_i (fq_ready),
    .entry_o       (fq_entry)
  );

  // Decouple the front end from a slow or stalled emitter.
  hsr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_entry_i (fq_entry),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_entry_o  (qb_entry)
  );

  // Emit letters one per transfer; drop the queue head after its last character.
  hsr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (qb_valid),
    .entry_ready_o (qb_ready),
    .entry_i       (qb_entry),
    .out_o         (out_o)
  );

endmodule
